// File: rtl/core/lpfd_pkg.sv
// ----------------------------------------------------------------------------
// lpfd_pkg: shared types for the length-prefixed frame deframer
// Result kinds, the parser's result bundle and the register reset value.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfd_pkg;

  // Result kind codes as seen on kind_o
  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_TAG_ONLY = 2'd1,
    KIND_ZERO_LEN = 2'd2,
    KIND_OVER_CAP = 2'd3
  } kind_e;

  // One result from the parser, valid for the cycle it steps
  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [7:0]  tag;
    logic [7:0]  data;
    logic        last;
  } res_t;

  localparam int unsigned       CapWidth     = 32;
  localparam logic [CapWidth-1:0] CapResetVal = 32'd1048576;

endpackage

`default_nettype wire

// File: rtl/core/lpfd_parse.sv
// ----------------------------------------------------------------------------
// lpfd_parse: frame parser state and single-pass step logic
// Consumes one byte per step, tracks prefix/tag/payload and flags errors.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfd_parse #(
  parameter int unsigned PrefixBytes = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire logic [7:0]                    byte_i,
  input  wire logic [lpfd_pkg::CapWidth-1:0] max_body_len_i,
  output lpfd_pkg::res_t                     result_o
);
  import lpfd_pkg::*;

  localparam int unsigned LenW  = 8 * PrefixBytes;
  localparam int unsigned CntW  = (PrefixBytes > 1) ? $clog2(PrefixBytes) : 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(PrefixBytes - 1);

  typedef enum logic [1:0] {
    ST_PREFIX,
    ST_TAG,
    ST_PAYLOAD,
    ST_HALT
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [LenW-1:0] accum_q, accum_d;
  logic [LenW-1:0] left_q, left_d;
  logic [7:0]      tag_q, tag_d;
  logic [LenW-1:0] accum_new;
  logic            left_one;
  res_t            res;

  assign accum_new = (accum_q << 8) | LenW'(byte_i);
  assign left_one  = (left_q == LenW'(1));

  // Step the parser on one byte
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    accum_d = accum_q;
    left_d  = left_q;
    tag_d   = tag_q;
    res     = '{valid: 1'b0, kind: KIND_DATA, tag: 8'd0, data: 8'd0, last: 1'b0};
    if (step_i) begin
      unique case (state_q)
        ST_PREFIX: begin
          accum_d = accum_new;
          if (cnt_q == LastCnt) begin
            cnt_d = '0;
            priority if (accum_new == '0) begin
              state_d = ST_HALT;
              res     = '{valid: 1'b1, kind: KIND_ZERO_LEN, tag: 8'd0, data: 8'd0,
                          last: 1'b1};
            end else if (CapWidth'(accum_new) > max_body_len_i) begin
              state_d = ST_HALT;
              res     = '{valid: 1'b1, kind: KIND_OVER_CAP, tag: 8'd0, data: 8'd0,
                          last: 1'b1};
            end else begin
              left_d  = accum_new;
              state_d = ST_TAG;
            end
          end else begin
            cnt_d = cnt_q + CntW'(1);
          end
        end
        ST_TAG: begin
          tag_d = byte_i;
          if (left_one) begin
            state_d = ST_PREFIX;
            accum_d = '0;
            res     = '{valid: 1'b1, kind: KIND_TAG_ONLY, tag: byte_i, data: 8'd0,
                        last: 1'b1};
          end else begin
            left_d  = left_q - LenW'(1);
            state_d = ST_PAYLOAD;
          end
        end
        ST_PAYLOAD: begin
          if (left_one) begin
            state_d = ST_PREFIX;
            accum_d = '0;
          end
          left_d = left_q - LenW'(1);
          res    = '{valid: 1'b1, kind: KIND_DATA, tag: tag_q, data: byte_i,
                     last: left_one};
        end
        ST_HALT: begin
          // drop every byte until reset
        end
        default: begin
          state_d = ST_HALT;
        end
      endcase
    end
  end

  assign result_o = res;

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_PREFIX;
      cnt_q   <= '0;
      accum_q <= '0;
      left_q  <= '0;
      tag_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      accum_q <= accum_d;
      left_q  <= left_d;
      tag_q   <= tag_d;
    end
  end

  // Halt is sticky until reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_HALT |=> state_q == ST_HALT)
    else $error("lpfd_parse: left halt state");

  // Results only come out of a step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> step_i)
    else $error("lpfd_parse: result without step");

  // Prefix counter stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LastCnt)
    else $error("lpfd_parse: prefix count out of range");

  // Error results always close with last and enter halt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (result_o.kind == KIND_ZERO_LEN || result_o.kind == KIND_OVER_CAP))
    |=> state_q == ST_HALT)
    else $error("lpfd_parse: error result without halt");

endmodule

`default_nettype wire

// File: rtl/core/length_prefixed_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_core: big-endian length-prefixed deframer
// Splits a byte stream into frames of length, tag and payload beats.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Beat contents
//  rx       in         rx_valid_i/rx_ready_o  rx_byte_i
//  out      out        out_valid_o/out_ready_i kind_o, frame_tag_o, data_byte_o, last_o
//  cfg      in         cfg_we_i              cfg_wdata_i (max_body_len)
//
//  One byte is taken per cycle unless the output stalls; a byte waits in the
//  input register until the parser steps on it; results go to the output register.
//  Unstalled throughput is one beat per cycle, set by the single-pass parser step.
//  Reset clears the parser to expect a new length prefix and sets the cap
//  to 1048576. A stalled output holds the input register; the parser steps
//  only when the output register is empty or being drained.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_frame_deframer_core #(
  parameter int unsigned PREFIX_BYTES = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [lpfd_pkg::CapWidth-1:0] cfg_wdata_i,
  input  wire logic                          rx_valid_i,
  output      logic                          rx_ready_o,
  input  wire logic [7:0]                    rx_byte_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [1:0]                    kind_o,
  output      logic [7:0]                    frame_tag_o,
  output      logic [7:0]                    data_byte_o,
  output      logic                          last_o
);
  import lpfd_pkg::*;

  logic [CapWidth-1:0] cap_q;
  logic                in_valid_q;
  logic [7:0]          in_byte_q;
  logic                out_valid_q;
  res_t                out_q;
  res_t                res;
  logic                advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign rx_ready_o = !in_valid_q || advance;

  // Hold the length cap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapResetVal;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_valid_i && rx_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_valid_i && rx_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  lpfd_parse #(
    .PrefixBytes(PREFIX_BYTES)
  ) u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .byte_i         (in_byte_q),
    .max_body_len_i (cap_q),
    .result_o       (res)
  );

  // Load or drain the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_q.kind;
  assign frame_tag_o = out_q.tag;
  assign data_byte_o = out_q.data;
  assign last_o      = out_q.last;

  // Input is blocked only behind a held beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("lpfd: input stalled without cause");

  // A stalled result is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !advance)
    else $error("lpfd: parser stepped over held result");

  // Error results always carry last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.kind == KIND_ZERO_LEN || out_q.kind == KIND_OVER_CAP))
    |-> out_q.last)
    else $error("lpfd: error result without last");

endmodule

`default_nettype wire

// File: sim/length_prefixed_frame_deframer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_core_tb: self-checking bench for the deframer
// Feeds framed byte streams (4-byte big-endian length, tag, payload) through
// the rx channel with random bursts and gaps while the out channel stalls on
// its own pattern. A behavioral deframer predicts each out beat, and every
// accepted beat is compared field by field. The cap register is retuned
// between idle points, including in the middle of a frame. The run ends with
// one length error, after which every byte must be dropped.
// ----------------------------------------------------------------------------

module length_prefixed_frame_deframer_core_tb;
  import lpfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_BEATS  = 1250;
  localparam int unsigned LATENCY_SLACK = 4;
  localparam int unsigned MAX_PRINTS    = 40;

  // Deframer parse position
  typedef enum logic [2:0] {
    PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3, PH_TAG, PH_BODY, PH_HALTED
  } parse_phase_e;

  // Ways to end the run with a length error
  typedef enum logic [2:0] {
    HALT_ZERO_LEN, HALT_OVER_SMALL, HALT_CAP_ZERO, HALT_OVER_RESET, HALT_OVER_TOP
  } halt_case_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] tag;
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CapWidth-1:0] cfg_wdata_i;
  logic                rx_valid_i;
  logic                rx_ready_o;
  logic [7:0]          rx_byte_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [1:0]          kind_o;
  logic [7:0]          frame_tag_o;
  logic [7:0]          data_byte_o;
  logic                last_o;

  // Deframer state as predicted from accepted beats
  parse_phase_e        parse_ph;
  logic [31:0]         len_gather;
  logic [31:0]         body_remaining;
  logic [7:0]          tag_hold;
  logic [CapWidth-1:0] body_cap;

  out_beat_t           expected_beats[$];
  logic [31:0]         cycle_count = 32'd0;
  int unsigned         mismatch_count = 0;
  int unsigned         rx_beats_sent = 0;
  int unsigned         burst_left = 0;
  logic [CapWidth-1:0] cap_now = CapResetVal;

  length_prefixed_frame_deframer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_valid_i  (rx_valid_i),
    .rx_ready_o  (rx_ready_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .frame_tag_o (frame_tag_o),
    .data_byte_o (data_byte_o),
    .last_o      (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Count cycles and give up on a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 32'd1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Stall the out channel: free running, random, periodic, coin flip
  always @(posedge clk_i) begin
    case (cycle_count[9:8])
      2'd0: out_ready_i <= 1'b1;
      2'd1: out_ready_i <= ($urandom_range(9) < 7);
      2'd2: out_ready_i <= ((cycle_count % 8) >= 3);
      default: out_ready_i <= 1'($urandom_range(1));
    endcase
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  function automatic void queue_beat(input kind_e kind, input logic [7:0] tag,
                                     input logic [7:0] data, input logic last);
    out_beat_t beat;
    beat.kind = kind;
    beat.tag  = tag;
    beat.data = data;
    beat.last = last;
    expected_beats.insert(expected_beats.size(), beat);
  endfunction

  // Advance the predicted deframer by one received byte
  function automatic void predict_deframe(input logic [7:0] b);
    case (parse_ph)
      PH_LEN0, PH_LEN1, PH_LEN2: begin
        len_gather = {len_gather[23:0], b};
        parse_ph = parse_phase_e'(parse_ph + 3'd1);
      end
      PH_LEN3: begin
        len_gather = {len_gather[23:0], b};
        if (len_gather == 32'd0) begin
          parse_ph = PH_HALTED;
          queue_beat(KIND_ZERO_LEN, 8'h00, 8'h00, 1'b1);
        end else if (len_gather > body_cap) begin
          parse_ph = PH_HALTED;
          queue_beat(KIND_OVER_CAP, 8'h00, 8'h00, 1'b1);
        end else begin
          body_remaining = len_gather;
          parse_ph = PH_TAG;
        end
      end
      PH_TAG: begin
        tag_hold = b;
        body_remaining = body_remaining - 32'd1;
        if (body_remaining == 32'd0) begin
          parse_ph = PH_LEN0;
          len_gather = 32'd0;
          queue_beat(KIND_TAG_ONLY, tag_hold, 8'h00, 1'b1);
        end else begin
          parse_ph = PH_BODY;
        end
      end
      PH_BODY: begin
        body_remaining = body_remaining - 32'd1;
        queue_beat(KIND_DATA, tag_hold, b, body_remaining == 32'd0);
        if (body_remaining == 32'd0) begin
          parse_ph = PH_LEN0;
          len_gather = 32'd0;
        end
      end
      default: begin
        // halted: drop the byte
      end
    endcase
  endfunction

  // Track register writes and accepted rx beats
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      parse_ph       = PH_LEN0;
      len_gather     = 32'd0;
      body_remaining = 32'd0;
      tag_hold       = 8'h00;
      body_cap       = CapResetVal;
    end else begin
      if (cfg_we_i) begin
        body_cap = cfg_wdata_i;
      end
      if (rx_valid_i && rx_ready_o) begin
        predict_deframe(rx_byte_i);
      end
    end
  end

  // Compare each accepted out beat with the oldest prediction
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind=%0d tag=%02h data=%02h last=%0b",
                                  kind_o, frame_tag_o, data_byte_o, last_o));
      end else begin
        want = expected_beats.pop_front();
        if (kind_o !== want.kind) begin
          report_mismatch($sformatf("kind %0d, want %0d", kind_o, want.kind));
        end
        if (frame_tag_o !== want.tag) begin
          report_mismatch($sformatf("frame_tag %02h, want %02h", frame_tag_o, want.tag));
        end
        if (data_byte_o !== want.data) begin
          report_mismatch($sformatf("data_byte %02h, want %02h", data_byte_o, want.data));
        end
        if (last_o !== want.last) begin
          report_mismatch($sformatf("last %0b, want %0b", last_o, want.last));
        end
      end
    end
  end

  // Send one rx beat, opening a random gap between bursts
  task automatic push_rx_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        rx_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!rx_ready_o);
    rx_beats_sent++;
  endtask

  // Hold rx idle until every predicted beat has come out
  task automatic drain_idle();
    rx_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (LATENCY_SLACK) @(posedge clk_i);
  endtask

  task automatic write_max_len(input logic [CapWidth-1:0] value);
    drain_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    cap_now = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Send one well-formed frame; optionally pause after byte pause_at to
  // retune the cap (fill < 0 gives random payload)
  task automatic send_frame(input logic [31:0] body_len, input logic [7:0] tag,
                            input int pause_at, input int fill);
    int          i;
    logic [7:0]  b;
    logic [31:0] new_cap;
    for (i = 0; i < body_len + 4; i++) begin
      if (i < 4) b = body_len[31 - 8*i -: 8];
      else if (i == 4) b = tag;
      else b = (fill < 0) ? 8'($urandom) : 8'(fill);
      push_rx_byte(b);
      if (i == pause_at) begin
        case ($urandom_range(4))
          0: new_cap = 32'd1;
          1: new_cap = $urandom_range(1, 64);
          2: new_cap = 32'hFFFF_FFFF;
          3: new_cap = $urandom | 32'd1;
          default: new_cap = CapResetVal;
        endcase
        // a cap written before the length check must still admit this frame
        if (i < 3 && new_cap < body_len) new_cap = body_len;
        write_max_len(new_cap);
      end
    end
  endtask

  task automatic test_short_frames();
    send_frame(32'd1, 8'hFF, -1, -1);
    send_frame(32'd2, 8'h00, -1, 8'h00);
  endtask

  task automatic test_cap_limits();
    write_max_len(32'd1);
    send_frame(32'd1, 8'h81, -1, -1);
    write_max_len(32'hFFFF_FFFF);
    send_frame(32'd2, 8'h7E, 1, 8'hFF);
  endtask

  task automatic test_random_stream();
    int unsigned stop_at;
    logic [31:0] span;
    logic [31:0] body_len;
    int          pause_at;
    stop_at = rx_beats_sent + RANDOM_BEATS;
    while (rx_beats_sent < stop_at) begin
      span = (cap_now > 32'd300) ? 32'd300 : cap_now;
      case ($urandom_range(19))
        0: body_len = $urandom_range(1, span);
        1: body_len = span;
        2, 3, 4, 5, 6: body_len = $urandom_range(1, (span > 64) ? 64 : span);
        default: body_len = $urandom_range(1, (span > 16) ? 16 : span);
      endcase
      pause_at = ($urandom_range(5) == 0) ? $urandom_range(0, body_len + 3) : -1;
      send_frame(body_len, 8'($urandom), pause_at, -1);
    end
  endtask

  // End with one length error, then check that everything is dropped
  task automatic test_error_halt();
    logic [31:0] bad_len;
    halt_case_e  which;
    int          i;
    which = halt_case_e'($urandom_range(4));
    case (which)
      HALT_ZERO_LEN: begin
        bad_len = 32'd0;
      end
      HALT_OVER_SMALL: begin
        write_max_len($urandom_range(1, 64));
        bad_len = cap_now + 32'd1;
      end
      HALT_CAP_ZERO: begin
        write_max_len(32'd0);
        bad_len = $urandom_range(1, 255);
      end
      HALT_OVER_RESET: begin
        write_max_len(CapResetVal);
        bad_len = CapResetVal + 32'd1;
      end
      default: begin
        write_max_len(32'hFFFF_FFFE);
        bad_len = 32'hFFFF_FFFF;
      end
    endcase
    for (i = 0; i < 4; i++) begin
      push_rx_byte(bad_len[31 - 8*i -: 8]);
    end
    send_frame(32'd2, 8'h3C, -1, -1);
    for (i = 0; i < 8; i++) begin
      push_rx_byte(8'($urandom));
    end
  endtask

  initial begin
    int unsigned waited;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    rx_valid_i  <= 1'b0;
    rx_byte_i   <= 8'h00;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_frames();
    test_cap_limits();
    test_random_stream();
    test_error_halt();

    // Let the pipe empty, then flag anything still owed
    rx_valid_i <= 1'b0;
    waited = 0;
    @(posedge clk_i);
    while (expected_beats.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (LATENCY_SLACK + 4) @(posedge clk_i);
    if (expected_beats.size() != 0) begin
      report_mismatch($sformatf("%0d predicted beats never came out",
                                expected_beats.size()));
    end
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
